@@ src/psm_pkg.sv @@
`timescale 1ns / 1ps

package psm_pkg;

  localparam int STORE_ENTRIES = 256;
  localparam int VALUE_W = 32;
  localparam int POS_W = 16;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      start_of_set;
  } in_item_t;

  typedef struct packed {
    logic             match_found;
    logic [POS_W-1:0] this_position;
    logic [POS_W-1:0] partner_position;
    logic             store_full;
  } out_item_t;

  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value;
    logic [VALUE_W-1:0] want;
    logic               want_ok;
    logic               clear;
    logic               done;
    logic               match;
    logic [POS_W-1:0]   partner;
    logic [POS_W-1:0]   position;
  } token_t;

endpackage

@@ src/psm_head.sv @@
`timescale 1ns / 1ps

module psm_head import psm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic                      in_valid,
  input  in_item_t                  in_data,
  input  logic signed [VALUE_W-1:0] target_sum,
  output token_t                    tok
);

  logic [POS_W-1:0]   position_counter;
  logic [POS_W-1:0]   position_counter_next;
  logic signed [VALUE_W:0] diff;
  token_t             tok_next;

  always_comb begin
    if (in_data.start_of_set) begin
      position_counter_next = POS_W'(1);
    end else if (position_counter == POS_MAX) begin
      position_counter_next = position_counter;
    end else begin
      position_counter_next = position_counter + POS_W'(1);
    end
    diff = {target_sum[VALUE_W-1], target_sum} - {in_data.value[VALUE_W-1], in_data.value};
    tok_next          = '0;
    tok_next.valid    = in_valid;
    tok_next.value    = in_data.value;
    tok_next.want     = diff[VALUE_W-1:0];
    tok_next.want_ok  = (diff[VALUE_W] == diff[VALUE_W-1]);
    tok_next.clear    = in_data.start_of_set;
    tok_next.position = position_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_counter <= '0;
      tok <= '0;
    end else if (advance) begin
      tok <= tok_next;
      if (in_valid) begin
        position_counter <= position_counter_next;
      end
    end
  end

endmodule

@@ src/psm_cell.sv @@
`timescale 1ns / 1ps

module psm_cell import psm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   advance,
  input  token_t tok_in,
  output token_t tok_out
);

  logic               entry_valid;
  logic [VALUE_W-1:0] entry_value;
  logic [POS_W-1:0]   entry_position;
  logic               live;
  logic               hit_same;
  logic               hit_want;
  logic               claim;
  token_t             tok_next;

  always_comb begin
    live     = entry_valid && !tok_in.clear;
    hit_same = live && (entry_value == tok_in.value);
    hit_want = live && tok_in.want_ok && !tok_in.match && (entry_value == tok_in.want);
    claim    = tok_in.valid && !tok_in.done && (hit_same || !live);
    tok_next = tok_in;
    if (hit_want) begin
      tok_next.match   = 1'b1;
      tok_next.partner = entry_position;
    end
    if (claim) begin
      tok_next.done = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
      tok_out <= '0;
    end else if (advance) begin
      tok_out <= tok_next;
      if (claim) begin
        entry_valid <= 1'b1;
      end else if (tok_in.valid && tok_in.clear) begin
        entry_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && claim) begin
      entry_value    <= tok_in.value;
      entry_position <= tok_in.position;
    end
  end

endmodule

@@ src/pair_sum_match_stream.sv @@
`timescale 1ns / 1ps

// Streaming pair-sum lookup over a row of compare cells.
// Input channel in_valid/in_ready/in_data carries a value and a start_of_set
// flag; output channel out_valid/out_ready/out_data returns one result per
// input transaction, in order. cfg_wr_en/cfg_wr_data write target_sum; write
// it only while no transaction is in flight.
// Each transaction walks the row of STORE_ENTRIES cells, one cell per cycle
// while the row advances: it looks up target_sum - value, updates its own
// value in place or claims the first free cell, and clears cells on the way
// when start_of_set is set. Each result passes the head register and then
// every cell register, so its delay is set by the length of the cell row.
// Throughput is one transaction per cycle while the receiver does not stall.
// Reset clears the valid bit of every cell, the position counter and target_sum
// at once; no clearing pass follows. When the receiver stalls with a result
// waiting, the whole row holds and in_ready drops until the result is taken.
module pair_sum_match_stream import psm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [VALUE_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data
);

  logic signed [VALUE_W-1:0] target_sum;
  logic                      advance;
  token_t                    tok [0:STORE_ENTRIES];

  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum <= '0;
    end else if (cfg_wr_en) begin
      target_sum <= cfg_wr_data;
    end
  end

  assign advance  = !tok[STORE_ENTRIES].valid || out_ready;
  assign in_ready = advance;

  psm_head u_head (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .target_sum (target_sum),
    .tok        (tok[0])
  );

  for (genvar i = 0; i < STORE_ENTRIES; i++) begin : g_cell
    psm_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  assign out_valid                 = tok[STORE_ENTRIES].valid;
  assign out_data.match_found      = tok[STORE_ENTRIES].match;
  assign out_data.this_position    = tok[STORE_ENTRIES].position;
  assign out_data.partner_position = tok[STORE_ENTRIES].partner;
  assign out_data.store_full       = !tok[STORE_ENTRIES].done;

  a_partner_earlier: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.match_found |->
      out_data.partner_position != '0 &&
      out_data.partner_position <= out_data.this_position)
    else $error("partner position not earlier than own position");

  a_no_partner: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.match_found |-> out_data.partner_position == '0)
    else $error("partner position set without a match");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  a_position_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.this_position != '0)
    else $error("result with zero position");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import psm_pkg::*;

  localparam int LIMIT = 800000;
  localparam int NUM_DIRECTED = 20;
  localparam int TAIL_ITEMS = 100;

  typedef struct {
    logic        load_target;
    logic [31:0] target;
    logic [31:0] value;
    logic        start;
    logic        typed;
    out_item_t   result;
  } stim_row_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [VALUE_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  logic row_typed = 1'b0;
  out_item_t row_result = '0;
  logic quiet = 1'b0;
  logic [31:0] drive_target = '0;

  logic [POS_W-1:0] seen_pos [bit [31:0]];
  logic [POS_W-1:0] set_position = '0;
  logic [31:0] model_target = '0;
  out_item_t result_q [$];

  int unsigned fail_count = 0;
  int unsigned items_in = 0;
  int unsigned results_checked = 0;
  int unsigned matches_seen = 0;
  int unsigned fulls_seen = 0;
  int unsigned cycle_count = 0;
  int ready_run = 0;
  int stall_run = 0;

  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{1'b0, 32'h0,        32'h5,        1'b1, 1'b1, '{1'b0, 16'd1, 16'd0, 1'b0}},
    '{1'b0, 32'h0,        32'hFFFFFFFB, 1'b0, 1'b1, '{1'b1, 16'd2, 16'd1, 1'b0}},
    '{1'b0, 32'h0,        32'h5,        1'b0, 1'b1, '{1'b1, 16'd3, 16'd2, 1'b0}},
    '{1'b0, 32'h0,        32'h0,        1'b0, 1'b1, '{1'b0, 16'd4, 16'd0, 1'b0}},
    '{1'b0, 32'h0,        32'h0,        1'b0, 1'b1, '{1'b1, 16'd5, 16'd4, 1'b0}},
    '{1'b0, 32'h0,        32'hFFFFFFFB, 1'b0, 1'b1, '{1'b1, 16'd6, 16'd3, 1'b0}},
    '{1'b1, 32'h7FFFFFFF, 32'h80000000, 1'b1, 1'b1, '{1'b0, 16'd1, 16'd0, 1'b0}},
    '{1'b0, 32'h0,        32'hFFFFFFFF, 1'b0, 1'b1, '{1'b0, 16'd2, 16'd0, 1'b0}},
    '{1'b0, 32'h0,        32'h7FFFFFFF, 1'b0, 1'b1, '{1'b0, 16'd3, 16'd0, 1'b0}},
    '{1'b0, 32'h0,        32'h0,        1'b0, 1'b1, '{1'b1, 16'd4, 16'd3, 1'b0}},
    '{1'b1, 32'h80000000, 32'h7FFFFFFF, 1'b1, 1'b1, '{1'b0, 16'd1, 16'd0, 1'b0}},
    '{1'b0, 32'h0,        32'h1,        1'b0, 1'b1, '{1'b0, 16'd2, 16'd0, 1'b0}},
    '{1'b0, 32'h0,        32'hFFFFFFFF, 1'b0, 1'b1, '{1'b0, 16'd3, 16'd0, 1'b0}},
    '{1'b0, 32'h0,        32'h80000000, 1'b0, 1'b1, '{1'b0, 16'd4, 16'd0, 1'b0}},
    '{1'b0, 32'h0,        32'h0,        1'b0, 1'b1, '{1'b1, 16'd5, 16'd4, 1'b0}},
    '{1'b1, 32'hFFFFFFFF, 32'h55555555, 1'b1, 1'b1, '{1'b0, 16'd1, 16'd0, 1'b0}},
    '{1'b0, 32'h0,        32'hAAAAAAAA, 1'b0, 1'b1, '{1'b1, 16'd2, 16'd1, 1'b0}},
    '{1'b0, 32'h0,        32'hFFFFFFFF, 1'b0, 1'b1, '{1'b0, 16'd3, 16'd0, 1'b0}},
    '{1'b0, 32'h0,        32'h0,        1'b1, 1'b1, '{1'b0, 16'd1, 16'd0, 1'b0}},
    '{1'b0, 32'h0,        32'hFFFFFFFF, 1'b0, 1'b1, '{1'b1, 16'd2, 16'd1, 1'b0}}
  };

  pair_sum_match_stream dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic out_item_t predict_pair(input in_item_t item);
    out_item_t res;
    logic signed [32:0] diff;
    bit [31:0] key;
    if (item.start_of_set) begin
      seen_pos.delete();
      set_position = '0;
    end
    if (set_position != POS_MAX) set_position++;
    res = '0;
    res.this_position = set_position;
    diff = {model_target[31], model_target} - {item.value[31], item.value};
    key = diff[31:0];
    if (diff[32] == diff[31] && seen_pos.exists(key)) begin
      res.match_found = 1'b1;
      res.partner_position = seen_pos[key];
    end
    key = item.value;
    if (seen_pos.exists(key) || seen_pos.num() < STORE_ENTRIES) begin
      seen_pos[key] = set_position;
    end else begin
      res.store_full = 1'b1;
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [15:0] expected,
                             input logic [15:0] actual);
    if (actual !== expected) begin
      if (fail_count < 40) $error("%s: expected %0d, got %0d", name, expected, actual);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst) begin
      seen_pos.delete();
      set_position = '0;
      model_target = '0;
    end else begin
      if (cfg_wr_en) model_target = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          if (fail_count < 40) $error("result with no transaction pending");
          fail_count++;
        end else begin
          want = result_q.pop_front();
          check_field("match_found", want.match_found, out_data.match_found);
          check_field("this_position", want.this_position, out_data.this_position);
          check_field("partner_position", want.partner_position, out_data.partner_position);
          check_field("store_full", want.store_full, out_data.store_full);
          results_checked++;
          if (want.match_found) matches_seen++;
          if (want.store_full) fulls_seen++;
        end
      end
      if (in_valid && in_ready) begin
        want = predict_pair(in_data);
        result_q.push_back(row_typed ? row_result : want);
        items_in++;
      end
    end
  end

  always @(negedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (ready_run > 0) begin
      out_ready <= 1'b1;
      ready_run--;
    end else if (stall_run > 0) begin
      out_ready <= 1'b0;
      stall_run--;
    end else begin
      ready_run = ($urandom_range(0, 99) < 20) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 30);
      stall_run = $urandom_range(1, 17);
      out_ready <= 1'b1;
    end
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_item(input in_item_t item, input logic typed, input out_item_t result);
    in_valid <= 1'b1;
    in_data <= item;
    row_typed <= typed;
    row_result <= result;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic maybe_pause(input int pct);
    if (pct != 0 && $urandom_range(0, 99) < pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
  endtask

  // drain every pending transaction, then load the register
  task automatic write_target(input logic [31:0] t);
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= t;
    drive_target = t;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_set(input int length, input int fresh_until);
    logic [31:0] set_vals [$];
    in_item_t item;
    int idle_pct;
    int pick;
    int n;
    idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
    for (n = 0; n < length; n++) begin
      pick = (n < fresh_until) ? 99 : $urandom_range(0, 99);
      if (set_vals.size() != 0 && pick < 35) begin
        item.value = drive_target - set_vals[$urandom_range(0, set_vals.size() - 1)];
      end else if (set_vals.size() != 0 && pick < 55) begin
        item.value = set_vals[$urandom_range(0, set_vals.size() - 1)];
      end else if (pick < 65) begin
        case ($urandom_range(0, 5))
          0: item.value = 32'h7FFFFFFF;
          1: item.value = 32'h80000000;
          2: item.value = 32'h0;
          3: item.value = 32'hFFFFFFFF;
          4: item.value = 32'h1;
          default: item.value = drive_target;
        endcase
      end else if (pick < 75) begin
        item.value = $urandom_range(0, 20) - 10;
      end else begin
        item.value = $urandom;
      end
      if (n == 0) item.start_of_set = ($urandom_range(0, 9) != 0) || (fresh_until != 0);
      else item.start_of_set = (fresh_until == 0) && ($urandom_range(0, 99) < 3);
      if (item.start_of_set) set_vals.delete();
      set_vals.push_back(item.value);
      maybe_pause(idle_pct);
      send_item(item, 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    in_item_t item;
    logic [31:0] t;
    int r;
    int phase;
    int sent;
    int len;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (r = 0; r < NUM_DIRECTED; r++) begin
      if (directed_rows[r].load_target) write_target(directed_rows[r].target);
      maybe_pause(20);
      item.value = directed_rows[r].value;
      item.start_of_set = directed_rows[r].start;
      send_item(item, directed_rows[r].typed, directed_rows[r].result);
    end

    for (phase = 0; phase < 7; phase++) begin
      case (phase)
        0: t = 32'h0;
        1: t = 32'h7FFFFFFF;
        2: t = 32'h80000000;
        3: t = 32'hFFFFFFFF;
        default: t = $urandom;
      endcase
      write_target(t);
      sent = 0;
      while (sent < 45) begin
        len = $urandom_range(1, 30);
        send_set(len, 0);
        sent += len;
      end
    end

    // overfill the store with one long set
    write_target($urandom);
    send_set(300, 270);

    // finish with back-to-back transactions and no stalls
    write_target(32'h7);
    quiet <= 1'b1;
    for (r = 0; r < TAIL_ITEMS; r++) begin
      item.value = $urandom_range(0, 7);
      item.start_of_set = (r == 0);
      send_item(item, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (result_q.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);

    $display("Checked %0d results from %0d transactions: %0d matches, %0d store-full drops,",
             results_checked, items_in, matches_seen, fulls_seen);
    $display("across extreme and random target sums, an overfilled store and a gapless tail.");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/psm_pkg.sv
src/psm_head.sv
src/psm_cell.sv
src/pair_sum_match_stream.sv
sim/testbench.sv
